>>> rtl/core/taabb_pkg.sv
package taabb_pkg;

	// Configuration register file: three packed coefficient rows.
	localparam int ROW_WIDTH       = 48;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int NUM_ROWS        = 3;

	// Coefficients are Q4.12: fraction bits dropped after the dot product.
	localparam int COEF_FRAC = 12;

	// Queue between the transform front and the box back.
	localparam int QUEUE_DEPTH     = 8;
	localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_WIDTH = QUEUE_PTR_WIDTH + 1;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_ROW_ZERO = 2'd0,
		REG_ROW_ONE  = 2'd1,
		REG_ROW_TWO  = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic                       not_empty;
		logic [QUEUE_CNT_WIDTH-1:0] count;
	} queue_status_t;

endpackage

>>> rtl/core/taabb_intf.sv
interface taabb_vtx_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic                          first_vertex;
	logic                          last_vertex;
	logic signed [COORD_WIDTH-1:0] pos_x;
	logic signed [COORD_WIDTH-1:0] pos_y;
	logic signed [COORD_WIDTH-1:0] pos_z;

	modport source (
		output valid, first_vertex, last_vertex, pos_x, pos_y, pos_z,
		input  ready
	);
	modport sink (
		input  valid, first_vertex, last_vertex, pos_x, pos_y, pos_z,
		output ready
	);
endinterface

interface taabb_box_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] lo_x;
	logic signed [COORD_WIDTH-1:0] lo_y;
	logic signed [COORD_WIDTH-1:0] lo_z;
	logic signed [COORD_WIDTH-1:0] hi_x;
	logic signed [COORD_WIDTH-1:0] hi_y;
	logic signed [COORD_WIDTH-1:0] hi_z;

	modport source (
		output valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z,
		input  ready
	);
	modport sink (
		input  valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z,
		output ready
	);
endinterface

>>> rtl/core/transformed_aabb_accumulator_core.sv
// A closing vertex passes the product and sum registers, the queue and the box slot.
// Throughput: one vertex per cycle; the front takes a vertex whenever its 8-entry
//   queue has a free slot counting the two transform stages in flight.
// Reset (arst_n low, asynchronous): matrix rows return to identity, both corners
//   clear to zero, the queue empties and no box is pending.
module transformed_aabb_accumulator_core #(
	parameter int COORD_WIDTH = 16,
	parameter int COEF_WIDTH  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	taabb_vtx_if.sink                             vtx,
	taabb_box_if.source                           box,
	input  logic                                  cfg_we,
	input  logic [taabb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [taabb_pkg::ROW_WIDTH-1:0]       cfg_data
);
	import taabb_pkg::*;

	localparam int ENTRY_W = 2 + 3 * COORD_WIDTH;

	// Front: vertex transfer, matrix rows, two multiply/add stages, rounding and
	// saturation. It pushes one entry per vertex: flags plus the three
	// transformed axes.
	logic               push;
	logic [ENTRY_W-1:0] push_data;
	logic               pop;
	logic [ENTRY_W-1:0] head_data;
	queue_status_t      q_status;

	taabb_front #(
		.COORD_WIDTH (COORD_WIDTH),
		.COEF_WIDTH  (COEF_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx       (vtx),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	// Queue: decouples the fixed-latency front from the back, which may hold
	// on a closing vertex while the previous box waits for transfer.
	taabb_queue #(
		.WIDTH (ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head_data (head_data),
		.status    (q_status)
	);

	// Back: load or widen the corners, and on a closing vertex register the box
	// into the output slot. Vertices that do not close a mesh drain past a
	// waiting box.
	taabb_back #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.head_data (head_data),
		.pop       (pop),
		.box       (box)
	);

endmodule

>>> rtl/core/taabb_queue.sv
module taabb_queue #(
	parameter int WIDTH = 50
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic [WIDTH-1:0]         push_data,
	input  logic                     pop,
	output logic [WIDTH-1:0]         head_data,
	output taabb_pkg::queue_status_t status
);
	import taabb_pkg::*;

	logic [WIDTH-1:0]           mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_q;
	logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_q;
	logic [QUEUE_CNT_WIDTH-1:0] count_q;

	// Space is reserved upstream, so a push never finds the queue full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	assign head_data        = mem_q[rd_ptr_q];
	assign status.not_empty = (count_q != '0);
	assign status.count     = count_q;

endmodule

>>> rtl/core/taabb_front.sv
module taabb_front #(
	parameter int COORD_WIDTH = 16,
	parameter int COEF_WIDTH  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	taabb_vtx_if.sink                            vtx,
	input  logic                                 cfg_we,
	input  logic [taabb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [taabb_pkg::ROW_WIDTH-1:0]      cfg_data,
	input  taabb_pkg::queue_status_t             q_status,
	output logic                                 push,
	output logic [2+3*COORD_WIDTH-1:0]           push_data
);
	import taabb_pkg::*;

	localparam int PROD_W = COORD_WIDTH + COEF_WIDTH;
	localparam int SUM_W  = (PROD_W + 2 > COORD_WIDTH + COEF_FRAC + 1) ?
		PROD_W + 2 : COORD_WIDTH + COEF_FRAC + 1;
	localparam int SH_W   = SUM_W - COEF_FRAC;
	localparam int EXT_W  = ROW_WIDTH + 3 * COEF_WIDTH;

	localparam logic signed [SUM_W-1:0] ROUND_HALF  = SUM_W'(longint'(1) <<< (COEF_FRAC - 1));
	localparam logic signed [SH_W-1:0]  SAT_HI      = SH_W'((longint'(1) <<< (COORD_WIDTH - 1)) - 1);
	localparam logic signed [SH_W-1:0]  SAT_LO      = -SAT_HI - SH_W'(1);
	localparam logic [63:0]             ONE_COEF    = 64'd1 << COEF_FRAC;

	// Matrix rows
	logic [ROW_WIDTH-1:0] row_q [NUM_ROWS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_ROWS; r++) begin
				row_q[r] <= ROW_WIDTH'(ONE_COEF << (r * COEF_WIDTH));
			end
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_ROW_ZERO: row_q[0] <= cfg_data;
				REG_ROW_ONE:  row_q[1] <= cfg_data;
				REG_ROW_TWO:  row_q[2] <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Credit check: every item in flight owns a queue slot.
	logic [QUEUE_CNT_WIDTH-1:0] reserved;
	logic                       accept;
	logic                       valid_s1;
	logic                       valid_s2;

	assign reserved  = q_status.count + QUEUE_CNT_WIDTH'(valid_s1) + QUEUE_CNT_WIDTH'(valid_s2);
	assign vtx.ready = (reserved < QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
	assign accept    = vtx.valid && vtx.ready;

	// Stage 1: nine products
	logic [EXT_W-1:0]               row_ext [NUM_ROWS];
	logic signed [COEF_WIDTH-1:0]   coef    [NUM_ROWS][3];
	logic signed [COORD_WIDTH-1:0]  pos     [3];
	logic signed [PROD_W-1:0]       prod_d  [NUM_ROWS][3];

	always_comb begin
		pos[0] = vtx.pos_x;
		pos[1] = vtx.pos_y;
		pos[2] = vtx.pos_z;
		for (int r = 0; r < NUM_ROWS; r++) begin
			// Zero-pad so a coefficient past bit 47 reads as zero.
			row_ext[r] = {{(3*COEF_WIDTH){1'b0}}, row_q[r]};
			for (int k = 0; k < 3; k++) begin
				coef[r][k]   = row_ext[r][k*COEF_WIDTH +: COEF_WIDTH];
				prod_d[r][k] = PROD_W'(pos[k]) * PROD_W'(coef[r][k]);
			end
		end
	end

	logic                     first_s1;
	logic                     last_s1;
	logic signed [PROD_W-1:0] prod_s1 [NUM_ROWS][3];

	// Stage 2: dot product plus rounding half
	logic                     first_s2;
	logic                     last_s2;
	logic signed [SUM_W-1:0]  sum_s2 [NUM_ROWS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= vtx.first_vertex;
		last_s1  <= vtx.last_vertex;
		prod_s1  <= prod_d;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		for (int r = 0; r < NUM_ROWS; r++) begin
			sum_s2[r] <= SUM_W'(prod_s1[r][0]) + SUM_W'(prod_s1[r][1])
				+ SUM_W'(prod_s1[r][2]) + ROUND_HALF;
		end
	end

	// Floor shift and saturate, then push
	logic signed [SH_W-1:0]        shifted [NUM_ROWS];
	logic signed [COORD_WIDTH-1:0] axis    [NUM_ROWS];

	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			shifted[r] = SH_W'(sum_s2[r] >>> COEF_FRAC);
			if (shifted[r] > SAT_HI) begin
				axis[r] = SAT_HI[COORD_WIDTH-1:0];
			end else if (shifted[r] < SAT_LO) begin
				axis[r] = SAT_LO[COORD_WIDTH-1:0];
			end else begin
				axis[r] = shifted[r][COORD_WIDTH-1:0];
			end
		end
	end

	assign push      = valid_s2;
	assign push_data = {first_s2, last_s2, axis[2], axis[1], axis[0]};

endmodule

>>> rtl/core/taabb_back.sv
module taabb_back #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  taabb_pkg::queue_status_t   q_status,
	input  logic [2+3*COORD_WIDTH-1:0] head_data,
	output logic                       pop,
	taabb_box_if.source                box
);
	import taabb_pkg::*;

	logic                          head_first;
	logic                          head_last;
	logic signed [COORD_WIDTH-1:0] t      [3];
	logic signed [COORD_WIDTH-1:0] low_q  [3];
	logic signed [COORD_WIDTH-1:0] high_q [3];
	logic signed [COORD_WIDTH-1:0] low_d  [3];
	logic signed [COORD_WIDTH-1:0] high_d [3];
	logic                          out_valid_q;

	assign head_first = head_data[2+3*COORD_WIDTH-1];
	assign head_last  = head_data[2+3*COORD_WIDTH-2];

	// Only a closing vertex needs the output slot.
	assign pop = q_status.not_empty && (!head_last || !out_valid_q || box.ready);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t[i] = head_data[i*COORD_WIDTH +: COORD_WIDTH];
			if (head_first) begin
				low_d[i]  = t[i];
				high_d[i] = t[i];
			end else begin
				low_d[i]  = (t[i] < low_q[i])  ? t[i] : low_q[i];
				high_d[i] = (t[i] > high_q[i]) ? t[i] : high_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				low_q[i]  <= '0;
				high_q[i] <= '0;
			end
		end else begin
			if (pop) begin
				low_q  <= low_d;
				high_q <= high_d;
			end
			if (pop && head_last) begin
				out_valid_q <= 1'b1;
			end else if (box.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_last) begin
			box.lo_x <= low_d[0];
			box.lo_y <= low_d[1];
			box.lo_z <= low_d[2];
			box.hi_x <= high_d[0];
			box.hi_y <= high_d[1];
			box.hi_z <= high_d[2];
		end
	end

	assign box.valid = out_valid_q;

endmodule

>>> verif/taabb_box_monitor.sv
module taabb_box_monitor (
	input  logic                                  clk,
	input  logic                                  arst_n,
	taabb_vtx_if                                  vtx,
	taabb_box_if                                  box,
	input  logic                                  cfg_we,
	input  logic [taabb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [taabb_pkg::ROW_WIDTH-1:0]       cfg_data,
	output int                                    box_errors,
	output int                                    boxes_due,
	output int                                    boxes_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import taabb_pkg::*;

	localparam int COORD_BITS   = 16;
	localparam int COEF_BITS    = 16;
	localparam int REPORT_LIMIT = 10;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	// Corner fields in port order: lo_x, lo_y, lo_z, hi_x, hi_y, hi_z.
	typedef logic [5:0][COORD_BITS-1:0] corners_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1 << COEF_FRAC);

	logic [ROW_WIDTH-1:0] matrix_row [NUM_ROWS];
	coord_t               box_low [3];
	coord_t               box_high [3];
	corners_t             boxes_expected [$];

	string corner_name [6] = '{"lo_x", "lo_y", "lo_z", "hi_x", "hi_y", "hi_z"};

	// Dot product of one Q4.12 row with a Q8.8 vertex, rounded half up to Q8.8, saturated.
	function automatic coord_t transform_axis(input logic [ROW_WIDTH-1:0] row,
			input coord_t x, input coord_t y, input coord_t z);
		longint acc;
		acc = longint'($signed(row[0*COEF_BITS +: COEF_BITS])) * longint'(x)
		    + longint'($signed(row[1*COEF_BITS +: COEF_BITS])) * longint'(y)
		    + longint'($signed(row[2*COEF_BITS +: COEF_BITS])) * longint'(z);
		acc = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
		if (acc > longint'(COORD_MAX))
			return COORD_MAX;
		if (acc < longint'(COORD_MIN))
			return COORD_MIN;
		return coord_t'(acc);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		coord_t   axis [3];
		corners_t seen;
		corners_t want;
		if (!arst_n) begin
			matrix_row[REG_ROW_ZERO] = {16'h0000, 16'h0000, COEF_ONE};
			matrix_row[REG_ROW_ONE]  = {16'h0000, COEF_ONE, 16'h0000};
			matrix_row[REG_ROW_TWO]  = {COEF_ONE, 16'h0000, 16'h0000};
			for (int a = 0; a < 3; a++) begin
				box_low[a]  = '0;
				box_high[a] = '0;
			end
			boxes_expected.delete();
		end else begin
			if (cfg_we && cfg_index < NUM_ROWS)
				matrix_row[cfg_index] = cfg_data;

			if (box.valid && box.ready) begin
				seen = {box.hi_z, box.hi_y, box.hi_x, box.lo_z, box.lo_y, box.lo_x};
				if (boxes_expected.size() == 0) begin
					if (box_errors < REPORT_LIMIT)
						$display("%0t: box transfer with none expected: %p", $realtime, seen);
					box_errors++;
				end else begin
					want = boxes_expected.pop_front();
					boxes_checked++;
					for (int f = 0; f < 6; f++) begin
						if (seen[f] !== want[f]) begin
							if (box_errors < REPORT_LIMIT)
								$display("%0t: box %0d field %s expected %0d got %0d",
									$realtime, boxes_checked, corner_name[f],
									$signed(want[f]), $signed(seen[f]));
							box_errors++;
						end
					end
				end
			end

			if (vtx.valid && vtx.ready) begin
				for (int a = 0; a < 3; a++)
					axis[a] = transform_axis(matrix_row[a], vtx.pos_x, vtx.pos_y, vtx.pos_z);
				for (int a = 0; a < 3; a++) begin
					if (vtx.first_vertex) begin
						box_low[a]  = axis[a];
						box_high[a] = axis[a];
					end else begin
						if (axis[a] < box_low[a])
							box_low[a] = axis[a];
						if (axis[a] > box_high[a])
							box_high[a] = axis[a];
					end
				end
				if (vtx.last_vertex)
					boxes_expected.push_back({box_high[2], box_high[1], box_high[0],
						box_low[2], box_low[1], box_low[0]});
			end
		end
		boxes_due = boxes_expected.size();
	end

endmodule

>>> verif/transformed_aabb_accumulator_core_test.sv
module transformed_aabb_accumulator_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import taabb_pkg::*;

	typedef logic signed [15:0] coord_t;
	typedef logic [15:0]        coef_t;

	// Hard ceiling on the run.
	localparam int CYCLE_LIMIT  = 200000;
	// Margin for the pipe to settle once no box is due.
	localparam int DRAIN_CYCLES = 12;
	// Output back-pressure stretch used to fill the internal queue.
	localparam int HOLD_CYCLES  = 400;

	localparam coef_t COEF_ONE  = 16'h1000;
	localparam coef_t COEF_HALF = 16'h0800;
	localparam coef_t COEF_MAX  = 16'h7fff;
	localparam coef_t COEF_MIN  = 16'h8000;
	localparam coord_t POS_MAX  = 16'sh7fff;
	localparam coord_t POS_MIN  = -16'sh8000;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [ROW_WIDTH-1:0]       cfg_data;

	taabb_vtx_if vtx_ch ();
	taabb_box_if box_ch ();

	int box_errors;
	int boxes_due;
	int boxes_checked;

	// Idle odds in percent for each side; changed per phase.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int vertices_sent = 0;
	int settings_loaded = 0;
	// Set at a rising edge, picked up by the receiver at the next falling edge.
	bit hold_request = 1'b0;

	transformed_aabb_accumulator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx       (vtx_ch),
		.box       (box_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	taabb_box_monitor box_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.vtx           (vtx_ch),
		.box           (box_ch),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.box_errors    (box_errors),
		.boxes_due     (boxes_due),
		.boxes_checked (boxes_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: count cycles in a process of its own and bail out past the limit.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles, %0d boxes still due", CYCLE_LIMIT, boxes_due);
		$display("Regression FAIL");
		$finish;
	end

	// Box receiver: drop ready at random, or hold it low for a long stretch on request.
	initial begin
		int hold_left;
		hold_left = 0;
		box_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				box_ch.ready <= 1'b0;
			end else begin
				box_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic logic [ROW_WIDTH-1:0] pack_row(input coef_t cx, input coef_t cy,
			input coef_t cz);
		return {cz, cy, cx};
	endfunction

	// Mix full-range noise, moderate gains, the extremes and zero.
	function automatic coef_t rand_coef();
		case ($urandom_range(3))
			0: return coef_t'($urandom);
			1: return coef_t'($urandom_range(16'h2000) - 16'h1000);
			2: begin
				case ($urandom_range(3))
					0: return COEF_MAX;
					1: return COEF_MIN;
					2: return COEF_ONE;
					default: return COEF_HALF;
				endcase
			end
			default: return '0;
		endcase
	endfunction

	function automatic logic [ROW_WIDTH-1:0] rand_row();
		return pack_row(rand_coef(), rand_coef(), rand_coef());
	endfunction

	// Mostly full-range positions, some near the origin, some pinned at the extremes.
	function automatic coord_t rand_coord();
		int pick;
		pick = $urandom_range(9);
		if (pick < 5)
			return coord_t'($urandom);
		if (pick < 8)
			return coord_t'($urandom_range(16'h0800) - 16'h0400);
		case ($urandom_range(4))
			0: return POS_MAX;
			1: return POS_MIN;
			2: return 16'sd1;
			3: return -16'sd1;
			default: return '0;
		endcase
	endfunction

	// Offer one vertex, idling first at the current odds; return once it transfers.
	task automatic send_vertex(input bit opens, input bit closes, input coord_t x,
			input coord_t y, input coord_t z);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			vtx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		vtx_ch.valid        <= 1'b1;
		vtx_ch.first_vertex <= opens;
		vtx_ch.last_vertex  <= closes;
		vtx_ch.pos_x        <= x;
		vtx_ch.pos_y        <= y;
		vtx_ch.pos_z        <= z;
		do
			@(posedge clk);
		while (!vtx_ch.ready);
		vertices_sent++;
	endtask

	// Drop valid, wait for every due box, then let trailing non-closing vertices settle.
	task automatic drain_boxes();
		@(negedge clk);
		vtx_ch.valid <= 1'b0;
		while (boxes_due != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write all three rows back to back; only call while the block is idle.
	task automatic load_matrix(input logic [ROW_WIDTH-1:0] row_x,
			input logic [ROW_WIDTH-1:0] row_y, input logic [ROW_WIDTH-1:0] row_z);
		reg_index_t           slot [3] = '{REG_ROW_ZERO, REG_ROW_ONE, REG_ROW_TWO};
		logic [ROW_WIDTH-1:0] value [3];
		value = '{row_x, row_y, row_z};
		for (int r = 0; r < 3; r++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= slot[r];
			cfg_data  <= value[r];
			@(posedge clk);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	// Mostly well-formed meshes with random content; the rest break the framing:
	// a mesh with no opener widens the previous box, one with no closer runs into
	// the next mesh, and a stray opener restarts the box halfway through.
	task automatic send_random_meshes(input int vertex_budget);
		int  sent;
		int  span;
		int  shape;
		bit  opens;
		bit  closes;
		sent = 0;
		while (sent < vertex_budget) begin
			shape = $urandom_range(99);
			span  = ($urandom_range(3) == 0) ? $urandom_range(16, 1) : $urandom_range(6, 1);
			for (int k = 0; k < span; k++) begin
				opens  = (k == 0);
				closes = (k == span - 1);
				if (shape < 8)
					opens = 1'b0;
				else if (shape < 14)
					closes = 1'b0;
				else if (shape < 18)
					opens = opens || (k == span / 2);
				send_vertex(opens, closes, rand_coord(), rand_coord(), rand_coord());
				sent++;
			end
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = REG_ROW_ZERO;
		cfg_data            = '0;
		vtx_ch.valid        = 1'b0;
		vtx_ch.first_vertex = 1'b0;
		vtx_ch.last_vertex  = 1'b0;
		vtx_ch.pos_x        = '0;
		vtx_ch.pos_y        = '0;
		vtx_ch.pos_z        = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: identity matrix out of reset. A closing vertex before any opener
		// widens the zero box; then a single-point mesh and a short full mesh.
		send_vertex(1'b0, 1'b1, 16'sh0100, -16'sh0200, POS_MAX);
		send_vertex(1'b1, 1'b1, POS_MAX, POS_MIN, '0);
		send_vertex(1'b1, 1'b0, POS_MIN, POS_MAX, -16'sd1);
		send_vertex(1'b0, 1'b0, 16'sd1, '0, POS_MIN);
		send_vertex(1'b0, 1'b1, 16'sh1234, -16'sh1234, POS_MAX);
		drain_boxes();

		// Extreme gains push x and y into saturation both ways; the third row
		// checks that exact halves round toward plus infinity.
		load_matrix(pack_row(COEF_MAX, COEF_MAX, COEF_MAX),
			pack_row(COEF_MIN, COEF_MIN, COEF_MIN),
			pack_row(COEF_HALF, -COEF_HALF, '0));
		send_vertex(1'b1, 1'b1, POS_MAX, POS_MAX, POS_MAX);
		send_vertex(1'b1, 1'b0, POS_MIN, POS_MIN, POS_MIN);
		send_vertex(1'b0, 1'b1, 16'sd1, '0, '0);
		send_vertex(1'b1, 1'b1, -16'sd1, '0, '0);
		send_vertex(1'b1, 1'b1, '0, 16'sd1, '0);
		send_vertex(1'b1, 1'b1, '0, -16'sd1, '0);
		drain_boxes();

		// All-zero and all-ones rows: everything collapses to zero or a tiny slope.
		load_matrix('0, '0, '0);
		send_vertex(1'b1, 1'b1, POS_MAX, POS_MIN, 16'sh5a5a);
		drain_boxes();
		load_matrix('1, '1, '1);
		send_vertex(1'b1, 1'b0, POS_MAX, POS_MAX, POS_MAX);
		send_vertex(1'b0, 1'b0, POS_MIN, POS_MIN, POS_MIN);
		send_vertex(1'b0, 1'b1, 16'sh00ff, -16'sh0100, '0);
		drain_boxes();

		// Random phase one: sender idles now and then, receiver idles often.
		send_idle_pct = 26;
		recv_idle_pct = 56;
		load_matrix(rand_row(), rand_row(), rand_row());
		send_random_meshes(100);
		drain_boxes();
		load_matrix(rand_row(), rand_row(), rand_row());
		send_random_meshes(100);
		drain_boxes();

		// Random phase two: the roles swap.
		send_idle_pct = 56;
		recv_idle_pct = 26;
		load_matrix(rand_row(), rand_row(), rand_row());
		send_random_meshes(100);
		drain_boxes();
		load_matrix(rand_row(), rand_row(), rand_row());
		send_random_meshes(100);
		drain_boxes();

		// Back-pressure: hold the output off while two-vertex meshes keep coming,
		// so the queue fills and the block must stall its input.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_matrix(rand_row(), rand_row(), rand_row());
		@(posedge clk);
		hold_request = 1'b1;
		for (int m = 0; m < 20; m++) begin
			send_vertex(1'b1, 1'b0, rand_coord(), rand_coord(), rand_coord());
			send_vertex(1'b0, 1'b1, rand_coord(), rand_coord(), rand_coord());
		end
		drain_boxes();

		// Random phase three: no idling on either side.
		load_matrix(rand_row(), rand_row(), rand_row());
		send_random_meshes(80);
		drain_boxes();
		load_matrix(pack_row(COEF_ONE, '0, '0), pack_row('0, COEF_ONE, '0),
			pack_row('0, '0, COEF_ONE));
		send_random_meshes(80);
		drain_boxes();

		$display("Covered %0d vertices and %0d checked boxes over %0d matrix settings,",
			vertices_sent, boxes_checked, settings_loaded);
		$display("with both sides idling in turn and one %0d-cycle output hold-off.",
			HOLD_CYCLES);
		if (box_errors == 0 && boxes_due == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/taabb_pkg.sv
rtl/core/taabb_intf.sv
rtl/core/taabb_queue.sv
rtl/core/taabb_front.sv
rtl/core/taabb_back.sv
rtl/core/transformed_aabb_accumulator_core.sv
verif/taabb_box_monitor.sv
verif/transformed_aabb_accumulator_core_test.sv
